FILE: rtl/core/dut_pkg.sv
package dut_pkg;

  localparam int unsigned AGING_RESET   = 30;
  localparam logic [15:0] QUERY_MASK    = 16'hFA00;
  localparam logic [15:0] RESP_MASK     = 16'hF800;
  localparam logic [15:0] RESP_VALUE    = 16'h8000;

  typedef enum logic [2:0] {
    ST_SHORT  = 3'd0,
    ST_NOTDNS = 3'd1,
    ST_ADDED  = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4,
    ST_HIT    = 3'd5,
    ST_MISS   = 3'd6
  } status_t;

  typedef struct packed {
    logic        v6;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [15:0] src_port;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] dst_port;
    logic [31:0] tstamp;
  } rec_t;

  typedef struct packed {
    logic        age_en;
    logic [31:0] now;
    logic [15:0] interval;
    logic        wr_en;
    logic        del_en;
    rec_t        rec;
  } cmd_t;

endpackage

FILE: rtl/core/dut_cell.sv
module dut_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  dut_pkg::cmd_t cmd,
  input  logic          wr_sel,
  input  logic          del_sel,
  output logic          valid,
  output logic          hit,
  output dut_pkg::rec_t rec
);

  logic          valid_r;
  logic          valid_nxt;
  dut_pkg::rec_t rec_r;
  logic [31:0]   age;

  assign age = cmd.now - rec_r.tstamp;
  assign hit = valid_r && rec_r.v6 == cmd.rec.v6 && rec_r.src_hi == cmd.rec.src_hi &&
               rec_r.src_lo == cmd.rec.src_lo && rec_r.src_port == cmd.rec.src_port;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.age_en && age >= {16'd0, cmd.interval}) valid_nxt = 1'b0;
    if (cmd.del_en && del_sel) valid_nxt = 1'b0;
    if (cmd.wr_en && wr_sel) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (cmd.wr_en && wr_sel) rec_r <= cmd.rec;
  end

  assign valid = valid_r;
  assign rec   = rec_r;

endmodule

FILE: rtl/core/dns_udp_conntrack_table.sv
// Tracks outgoing DNS queries in a row of TABLE_ENTRIES cells and matches
// incoming responses against them. Packets are handled one at a time: capture
// on the accepting edge, an aging pass over all cells in parallel (S_AGE), then
// key compare with lowest free / matching cell select plus cell update and
// result register (S_ACT), then the result is presented until out_tready is high
// (S_OUT); the next packet is taken in the cycle after the result has been handed on.
module dns_udp_conntrack_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MIN_PAYLOAD   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type, is_ipv6, src_ip_hi, src_ip_lo, src_port, dst_ip_hi, dst_ip_lo,
  // dst_port, dns_flags_word, dns_count_word, payload_length, now_seconds
  input  logic [375:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted, status, orig_dst_ip_hi, orig_dst_ip_lo, orig_dst_port
  output logic [151:0] out_tdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_AGE = 4'b0010, S_ACT = 4'b0100, S_OUT = 4'b1000
  } fsm_t;

  fsm_t         st_r;
  logic [15:0]  interval_r;
  logic [375:0] pkt_r;
  logic         started_r;
  logic [31:0]  last_r;
  logic [151:0] res_r;

  logic         incoming, v6;
  logic [15:0]  flags, count, len;
  logic [31:0]  now;
  dut_pkg::rec_t key;
  dut_pkg::cmd_t cmd;

  logic [TABLE_ENTRIES-1:0] vld, hits, wsel, dsel;
  dut_pkg::rec_t            recs [TABLE_ENTRIES];
  logic [IW-1:0]            hidx;
  logic                     anyhit, anyfree;

  assign incoming = pkt_r[0];
  assign v6       = pkt_r[1];
  assign flags    = pkt_r[305:290];
  assign count    = pkt_r[321:306];
  assign len      = pkt_r[337:322];
  assign now      = pkt_r[369:338];

  always_comb begin
    key.v6       = v6;
    key.src_hi   = v6 ? pkt_r[65:2] : 64'd0;
    key.src_lo   = v6 ? pkt_r[129:66] : {32'd0, pkt_r[97:66]};
    key.src_port = pkt_r[145:130];
    key.dst_hi   = v6 ? pkt_r[209:146] : 64'd0;
    key.dst_lo   = v6 ? pkt_r[273:210] : {32'd0, pkt_r[241:210]};
    key.dst_port = pkt_r[289:274];
    key.tstamp   = now;
  end

  logic qry_ok, rsp_ok, is_short, do_age, zero_port;
  assign is_short  = len < 16'(MIN_PAYLOAD);
  assign qry_ok    = (flags & dut_pkg::QUERY_MASK) == 16'd0 && count == 16'd0;
  assign rsp_ok    = (flags & dut_pkg::RESP_MASK) == dut_pkg::RESP_VALUE;
  assign do_age    = started_r && (now - last_r) >= {16'd0, interval_r};
  assign zero_port = key.src_port == 16'd0 || key.dst_port == 16'd0;

  always_comb begin
    anyhit  = |hits;
    anyfree = ~&vld;
    hidx    = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) if (hits[i]) hidx = IW'(i);
    wsel = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) if (!vld[i]) wsel = '0 | (TABLE_ENTRIES'(1) << i);
    dsel = '0;
    dsel[hidx] = anyhit;
  end

  always_comb begin
    cmd          = '0;
    cmd.now      = now;
    cmd.interval = interval_r;
    cmd.rec      = key;
    cmd.age_en   = st_r == S_AGE && !is_short && do_age;
    cmd.wr_en    = st_r == S_ACT && !is_short && !incoming && qry_ok && !zero_port &&
                   !anyhit && anyfree;
    cmd.del_en   = st_r == S_ACT && !is_short && incoming && rsp_ok;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dut_cell u_cell (
      .clk, .rst_n, .cmd,
      .wr_sel (wsel[g]), .del_sel(dsel[g]),
      .valid  (vld[g]), .hit(hits[g]), .rec(recs[g])
    );
  end

  logic [2:0]   stv;
  logic [151:0] res_nxt;
  always_comb begin
    res_nxt = '0;
    if (is_short) stv = dut_pkg::ST_SHORT;
    else if (!incoming) begin
      if (!qry_ok) stv = dut_pkg::ST_NOTDNS;
      else if (zero_port || anyhit) stv = dut_pkg::ST_DUP;
      else if (!anyfree) stv = dut_pkg::ST_FULL;
      else stv = dut_pkg::ST_ADDED;
    end else begin
      if (!rsp_ok) stv = dut_pkg::ST_NOTDNS;
      else if (anyhit) begin
        stv = dut_pkg::ST_HIT;
        res_nxt[67:4]    = recs[hidx].dst_hi;
        res_nxt[131:68]  = recs[hidx].dst_lo;
        res_nxt[147:132] = recs[hidx].dst_port;
      end else stv = dut_pkg::ST_MISS;
    end
    res_nxt[0]   = stv == dut_pkg::ST_ADDED || stv == dut_pkg::ST_HIT;
    res_nxt[3:1] = stv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      interval_r <= 16'(dut_pkg::AGING_RESET);
      started_r  <= 1'b0;
      last_r     <= '0;
    end else begin
      if (cfg_we) interval_r <= cfg_wdata;
      unique case (st_r)
        S_IDLE: if (in_tvalid) st_r <= S_AGE;
        S_AGE: begin
          st_r <= S_ACT;
          if (!is_short) begin
            if (!started_r) begin
              started_r <= 1'b1;
              last_r    <= now;
            end else if (do_age) last_r <= now;
          end
        end
        S_ACT:  st_r <= S_OUT;
        S_OUT:  if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    if (st_r == S_IDLE && in_tvalid) pkt_r <= in_tdata;
    if (st_r == S_ACT) res_r <= res_nxt;
  end

  assign in_tready  = st_r == S_IDLE;
  assign out_tvalid = st_r == S_OUT;
  assign out_tdata  = res_r;

endmodule
